>>> src/ukse_pkg.sv
// ----------------------------------------------------------------------------
// ukse_pkg
// Shared constants and controller/datapath interface types for the key set
// engine.
// ----------------------------------------------------------------------------
package ukse_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RUN_W    = $clog2(2 * CAPACITY + 1);
    localparam int SIZE_W   = 6;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 3;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_INS_A  = 3'd0;
    localparam kind_t KIND_INS_B  = 3'd1;
    localparam kind_t KIND_SRCH_A = 3'd2;
    localparam kind_t KIND_SRCH_B = 3'd3;
    localparam kind_t KIND_UNION  = 3'd4;
    localparam kind_t KIND_INTER  = 3'd5;

    typedef struct packed {
        logic cap_in;      // latch request key
        logic insert;      // request is an insert
        logic scan_start;  // reset inner scan, latch target
        logic scan_tgt_b;  // inner scan target is set B
        logic scan_run;    // advance inner scan
        logic i_clr;       // reset outer index, latch source
        logic src_b;       // outer source is set B
        logic fetch;       // read source at outer index
        logic i_inc;
        logic load_probe;  // probe <= fetched source key
        logic n_load_a;    // run count <= count of A
        logic n_clr;
        logic n_inc;
        logic e_clr;
        logic out_single;  // insert/search result, commit insert
        logic out_run;     // run element
        logic out_empty;   // empty run marker
    } ukse_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic i_end;
        logic n_zero;
        logic out_free;
    } ukse_stat_t;

endpackage

>>> src/unordered_key_set_engine_top.sv
// ----------------------------------------------------------------------------
// unordered_key_set_engine_top
// Two bounded unordered key sets with insert, search, and streamed union and
// intersection runs.
//
// Channel  Dir  tdata (low bit up)               tuser (low bit up)             tlast
// s_       in   key[31:0]                        kind[2:0]                      -
// m_       out  out_key[31:0], set_size[37:32]   found, full_reject, empty_run  last
//
// Insert/search: the addressed set is scanned, then the result is issued and the
// next request can be accepted; one key compare per cycle against a registered
// store read.
// Union and intersection: a count pass, then an emit pass over the run
// elements.
// Reset clears both counts; no store clearing pass. One request is in work
// at a time; a held output result stalls the sequencer only when it must emit.
// ----------------------------------------------------------------------------
module unordered_key_set_engine_top import ukse_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key
    input  logic [KIND_W-1:0]   s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_key, set_size, zero pad
    output logic [M_USER_W-1:0] m_tuser,   // found, full_reject, empty_run
    output logic                m_tlast
);

    ukse_cmd_t  cmd;
    ukse_stat_t stat;

    ukse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    ukse_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> src/ukse_datapath.sv
// ----------------------------------------------------------------------------
// ukse_datapath
// Key stores for sets A and B, counts, membership scan unit, run counters
// and the output register.
// ----------------------------------------------------------------------------
module ukse_datapath import ukse_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  ukse_cmd_t           cmd,
    output ukse_stat_t          stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast
);

    logic [KEY_W-1:0]  mem_a [CAPACITY];
    logic [KEY_W-1:0]  mem_b [CAPACITY];
    logic [KEY_W-1:0]  rd_a_reg;
    logic [KEY_W-1:0]  rd_b_reg;
    logic [KEY_W-1:0]  probe_reg;
    logic [CNT_W-1:0]  cnt_a_reg;
    logic [CNT_W-1:0]  cnt_b_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [CNT_W-1:0]  i_reg;
    logic              pend_reg;
    logic              hit_reg;
    logic              tgt_b_reg;
    logic              src_b_reg;
    logic              ins_reg;
    logic [RUN_W-1:0]  n_reg;
    logic [RUN_W-1:0]  e_reg;

    logic              m_valid_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic              m_found_reg;
    logic              m_rej_reg;
    logic              m_empty_reg;
    logic              m_last_reg;
    logic [SIZE_W-1:0] m_size_reg;

    logic [CNT_W-1:0]  cnt_tgt;
    logic [CNT_W-1:0]  cnt_src;
    logic [CNT_W-1:0]  cnt_after;
    logic [KEY_W-1:0]  tgt_data;
    logic [KEY_W-1:0]  src_data;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [RUN_W-1:0]  e_plus;
    logic              scan_issue;
    logic              full;
    logic              do_ins;
    logic              out_free;

    assign cnt_tgt    = tgt_b_reg ? cnt_b_reg : cnt_a_reg;
    assign cnt_src    = src_b_reg ? cnt_b_reg : cnt_a_reg;
    assign tgt_data   = tgt_b_reg ? rd_b_reg : rd_a_reg;
    assign src_data   = src_b_reg ? rd_b_reg : rd_a_reg;
    assign scan_issue = cmd.scan_run && (j_reg < cnt_tgt);
    assign raddr_a    = (cmd.fetch && !src_b_reg) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign raddr_b    = (cmd.fetch && src_b_reg) ? i_reg[IDX_W-1:0] : j_reg[IDX_W-1:0];
    assign full       = (cnt_tgt == CNT_W'(CAPACITY));
    assign do_ins     = ins_reg && !hit_reg && !full;
    assign cnt_after  = cnt_tgt + CNT_W'(do_ins);
    assign e_plus     = e_reg + RUN_W'(1);
    assign out_free   = !m_valid_reg || m_tready;

    assign stat.scan_done = !(j_reg < cnt_tgt) && !pend_reg;
    assign stat.hit       = hit_reg;
    assign stat.i_end     = !(i_reg < cnt_src);
    assign stat.n_zero    = (n_reg == '0);
    assign stat.out_free  = out_free;

    // key stores, registered read
    always_ff @(posedge aclk) begin
        if (cmd.out_single && do_ins && !tgt_b_reg) begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= probe_reg;
        end
        if (cmd.out_single && do_ins && tgt_b_reg) begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= probe_reg;
        end
        rd_a_reg <= mem_a[raddr_a];
        rd_b_reg <= mem_b[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            j_reg       <= '0;
            i_reg       <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            tgt_b_reg   <= 1'b0;
            src_b_reg   <= 1'b0;
            ins_reg     <= 1'b0;
            n_reg       <= '0;
            e_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cap_in) begin
                ins_reg <= cmd.insert;
            end

            if (cmd.scan_start) begin
                j_reg     <= '0;
                pend_reg  <= 1'b0;
                hit_reg   <= 1'b0;
                tgt_b_reg <= cmd.scan_tgt_b;
            end else if (cmd.scan_run) begin
                pend_reg <= scan_issue;
                if (scan_issue) begin
                    j_reg <= j_reg + CNT_W'(1);
                end
                if (pend_reg && (tgt_data == probe_reg)) begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.i_clr) begin
                i_reg     <= '0;
                src_b_reg <= cmd.src_b;
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + CNT_W'(1);
            end

            if (cmd.n_load_a) begin
                n_reg <= RUN_W'(cnt_a_reg);
            end else if (cmd.n_clr) begin
                n_reg <= '0;
            end else if (cmd.n_inc) begin
                n_reg <= n_reg + RUN_W'(1);
            end

            if (cmd.e_clr) begin
                e_reg <= '0;
            end else if (cmd.out_run) begin
                e_reg <= e_plus;
            end

            if (cmd.out_single && do_ins) begin
                if (tgt_b_reg) begin
                    cnt_b_reg <= cnt_after;
                end else begin
                    cnt_a_reg <= cnt_after;
                end
            end

            if (cmd.out_single || cmd.out_run || cmd.out_empty) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // probe and output payload
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            probe_reg <= s_tdata[KEY_W-1:0];
        end else if (cmd.load_probe) begin
            probe_reg <= src_data;
        end

        if (cmd.out_single) begin
            m_key_reg   <= probe_reg;
            m_found_reg <= hit_reg;
            m_rej_reg   <= ins_reg && !hit_reg && full;
            m_empty_reg <= 1'b0;
            m_last_reg  <= 1'b1;
            m_size_reg  <= SIZE_W'(cnt_after);
        end else if (cmd.out_run) begin
            m_key_reg   <= probe_reg;
            m_found_reg <= 1'b0;
            m_rej_reg   <= 1'b0;
            m_empty_reg <= 1'b0;
            m_last_reg  <= (e_plus == n_reg);
            m_size_reg  <= SIZE_W'(n_reg);
        end else if (cmd.out_empty) begin
            m_key_reg   <= '0;
            m_found_reg <= 1'b0;
            m_rej_reg   <= 1'b0;
            m_empty_reg <= 1'b1;
            m_last_reg  <= 1'b1;
            m_size_reg  <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - KEY_W - SIZE_W){1'b0}}, m_size_reg, m_key_reg};
    assign m_tuser  = {m_empty_reg, m_rej_reg, m_found_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> src/ukse_ctrl.sv
// ----------------------------------------------------------------------------
// ukse_ctrl
// Sequencer for insert, search, union and intersection requests.
// ----------------------------------------------------------------------------
module ukse_ctrl import ukse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  kind_t      kind,
    input  ukse_stat_t stat,
    output ukse_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_RESULT1,
        ST_FETCH,
        ST_LOAD,
        ST_SCAN,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        PH_CNT,
        PH_EMIT_A,
        PH_EMIT_S
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   union_reg, union_next;
    logic   keep;

    assign keep     = union_reg ? !stat.hit : stat.hit;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        union_next = union_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    unique case (kind) inside
                        KIND_INS_A, KIND_INS_B, KIND_SRCH_A, KIND_SRCH_B: begin
                            cmd.insert     = (kind == KIND_INS_A) || (kind == KIND_INS_B);
                            cmd.scan_start = 1'b1;
                            cmd.scan_tgt_b = (kind == KIND_INS_B) || (kind == KIND_SRCH_B);
                            state_next     = ST_SCAN1;
                        end
                        KIND_UNION: begin
                            union_next   = 1'b1;
                            phase_next   = PH_CNT;
                            cmd.i_clr    = 1'b1;
                            cmd.src_b    = 1'b1;
                            cmd.n_load_a = 1'b1;
                            state_next   = ST_FETCH;
                        end
                        KIND_INTER: begin
                            union_next = 1'b0;
                            phase_next = PH_CNT;
                            cmd.i_clr  = 1'b1;
                            cmd.n_clr  = 1'b1;
                            state_next = ST_FETCH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN1: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_RESULT1;
                end
            end
            ST_RESULT1: begin
                if (stat.out_free) begin
                    cmd.out_single = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (stat.i_end) begin
                    unique case (phase_reg)
                        PH_CNT: begin
                            if (stat.n_zero) begin
                                state_next = ST_EMPTY;
                            end else begin
                                cmd.i_clr  = 1'b1;
                                cmd.e_clr  = 1'b1;
                                phase_next = union_reg ? PH_EMIT_A : PH_EMIT_S;
                            end
                        end
                        PH_EMIT_A: begin
                            cmd.i_clr  = 1'b1;
                            cmd.src_b  = 1'b1;
                            phase_next = PH_EMIT_S;
                        end
                        PH_EMIT_S: begin
                            state_next = ST_IDLE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end else begin
                    cmd.fetch  = 1'b1;
                    cmd.i_inc  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_probe = 1'b1;
                if (phase_reg == PH_EMIT_A) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_tgt_b = !union_reg;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    if (phase_reg == PH_CNT) begin
                        cmd.n_inc  = keep;
                        state_next = ST_FETCH;
                    end else begin
                        state_next = keep ? ST_EMIT : ST_FETCH;
                    end
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_run = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_EMPTY: begin
                if (stat.out_free) begin
                    cmd.out_empty = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_CNT;
            union_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            union_reg <= union_next;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key set engine. Directed and random insert,
// search, union and intersection requests are sent while both streams stall
// at random. A tracker keeps its own copy of both sets, predicts every result
// and compares each one, field by field, as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
    import ukse_pkg::*;

    localparam kind_t KIND_RSVD_6     = 3'd6;
    localparam kind_t KIND_RSVD_7     = 3'd7;
    localparam int    RANDOM_REQS     = 400;
    localparam int    HOLD_OFF_CYCLES = 400;
    localparam int    DRAIN_CYCLES    = 2500;

    typedef struct packed {
        logic [KEY_W-1:0]  out_key;
        logic              found;
        logic              full_reject;
        logic              empty_run;
        logic              last;
        logic [SIZE_W-1:0] set_size;
    } set_result_t;

    class key_set_tracker;
        logic [KEY_W-1:0] set_a[$];
        logic [KEY_W-1:0] set_b[$];
        set_result_t      pending_results[$];
        int               errors = 0;

        function bit holds(logic [KEY_W-1:0] keys[$], logic [KEY_W-1:0] key);
            foreach (keys[i]) begin
                if (keys[i] == key) return 1'b1;
            end
            return 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void apply_request(kind_t kind, logic [KEY_W-1:0] key);
            set_result_t      r;
            logic [KEY_W-1:0] run_keys[$];
            bit               on_b;
            bit               hit;
            r = '0;
            case (kind) inside
                KIND_INS_A, KIND_INS_B, KIND_SRCH_A, KIND_SRCH_B: begin
                    on_b = (kind == KIND_INS_B || kind == KIND_SRCH_B);
                    if (on_b) hit = holds(set_b, key);
                    else hit = holds(set_a, key);
                    if ((kind == KIND_INS_A || kind == KIND_INS_B) && !hit) begin
                        if ((on_b ? set_b.size() : set_a.size()) >= CAPACITY)
                            r.full_reject = 1'b1;
                        else if (on_b)
                            set_b.push_back(key);
                        else
                            set_a.push_back(key);
                    end
                    r.out_key  = key;
                    r.found    = hit;
                    r.last     = 1'b1;
                    r.set_size = SIZE_W'(on_b ? set_b.size() : set_a.size());
                    pending_results.push_back(r);
                end
                KIND_UNION: begin
                    run_keys = set_a;
                    foreach (set_b[i]) begin
                        if (!holds(set_a, set_b[i])) run_keys.push_back(set_b[i]);
                    end
                end
                KIND_INTER: begin
                    foreach (set_a[i]) begin
                        if (holds(set_b, set_a[i])) run_keys.push_back(set_a[i]);
                    end
                end
                default: ;  // reserved kinds: no result
            endcase
            if (kind == KIND_UNION || kind == KIND_INTER) begin
                if (run_keys.size() == 0) begin
                    r.empty_run = 1'b1;
                    r.last      = 1'b1;
                    pending_results.push_back(r);
                end
                foreach (run_keys[i]) begin
                    r.out_key  = run_keys[i];
                    r.last     = (i == run_keys.size() - 1);
                    r.set_size = SIZE_W'(run_keys.size());
                    pending_results.push_back(r);
                end
            end
        endfunction

        function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void match_result(logic [M_DATA_W-1:0] tdata,
                                   logic [M_USER_W-1:0] tuser, logic tlast);
            set_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0h user %0h last %0b",
                         $time, "actual key", tdata[KEY_W-1:0], tuser, tlast);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            compare("out_key", 64'(e.out_key), 64'(tdata[KEY_W-1:0]));
            compare("set_size", 64'(e.set_size), 64'(tdata[KEY_W +: SIZE_W]));
            compare("tdata pad", 64'd0, 64'(tdata[M_DATA_W-1:KEY_W+SIZE_W]));
            compare("found", 64'(e.found), 64'(tuser[0]));
            compare("full_reject", 64'(e.full_reject), 64'(tuser[1]));
            compare("empty_run", 64'(e.empty_run), 64'(tuser[2]));
            compare("last", 64'(e.last), 64'(tlast));
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    key_set_tracker   tracker = new();
    logic [KEY_W-1:0] used_keys[$];
    bit               hold_off_req = 1'b0;

    unordered_key_set_engine_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // often keys seen before, so sets overlap and inserts repeat
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 32'h0000_0001;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_request(kind_t kind, logic [KEY_W-1:0] key);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        tracker.apply_request(kind, key);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin : sink
        int gap;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : source
        int               sent;
        int               r;
        bit               hold_off_done;
        bit               pause_done;
        kind_t            kind;
        logic [KEY_W-1:0] key;
        sent          = 0;
        hold_off_done = 1'b0;
        pause_done    = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty sets, one-sided sets, duplicates, extremes, reserved kinds
        send_request(KIND_UNION, 32'h0);
        send_request(KIND_INTER, 32'hFFFF_FFFF);
        send_request(KIND_SRCH_A, 32'h0);
        send_request(KIND_INS_B, 32'h1234_5678);
        send_request(KIND_UNION, 32'h0);
        send_request(KIND_INTER, 32'h0);
        send_request(KIND_INS_A, 32'h0);
        send_request(KIND_INS_A, 32'hFFFF_FFFF);
        send_request(KIND_INS_A, 32'h0);
        send_request(KIND_INTER, 32'h0);
        send_request(KIND_INS_B, 32'hFFFF_FFFF);
        send_request(KIND_SRCH_A, 32'hFFFF_FFFF);
        send_request(KIND_SRCH_B, 32'h0);
        send_request(KIND_UNION, 32'hFFFF_FFFF);
        send_request(KIND_INTER, 32'hFFFF_FFFF);
        send_request(KIND_RSVD_6, 32'h0);
        send_request(KIND_RSVD_7, 32'hFFFF_FFFF);
        send_request(KIND_INS_B, 32'h0);
        send_request(KIND_SRCH_B, 32'h0);
        send_request(KIND_SRCH_A, 32'hA5A5_5A5A);
        send_request(KIND_UNION, 32'h0);
        used_keys = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678};

        while (sent < RANDOM_REQS) begin
            r   = $urandom_range(0, 99);
            key = pick_key();
            if (r < 22) kind = KIND_INS_A;
            else if (r < 44) kind = KIND_INS_B;
            else if (r < 60) kind = KIND_SRCH_A;
            else if (r < 76) kind = KIND_SRCH_B;
            else if (r < 86) kind = KIND_UNION;
            else if (r < 95) kind = KIND_INTER;
            else kind = $urandom_range(0, 1) ? KIND_RSVD_6 : KIND_RSVD_7;
            if (kind == KIND_INS_A || kind == KIND_INS_B) used_keys.push_back(key);
            send_request(kind, key);
            if (kind != KIND_RSVD_6 && kind != KIND_RSVD_7) sent++;
            if (sent >= 100 && !hold_off_done) begin
                hold_off_req  = 1'b1;
                hold_off_done = 1'b1;
            end
            if (sent >= 250 && !pause_done) begin
                wait_results_drained();
                pause_done = 1'b1;
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
src/ukse_pkg.sv
src/ukse_datapath.sv
src/ukse_ctrl.sv
src/unordered_key_set_engine_top.sv
tb/tb_top.sv
